// File: design/mabp_pkg.sv
// ----------------------------------------------------------------------------
// mabp_pkg
// shared types, constants and helper functions of the motor angle to beam
// polynomial converter
// ----------------------------------------------------------------------------
package mabp_pkg;

    // polynomial degree default and field widths
    localparam int POLY_DEGREE_DEF = 6;
    localparam int POS_W           = 16;
    localparam int TILT_W          = 15;
    localparam int COEF_W          = 32;
    localparam int IDX_W           = 5;
    localparam int DIFF_W          = 18;
    localparam int U_W             = TILT_W + 3;

    // angles in 1/128 degree
    localparam logic signed [DIFF_W-1:0] HALF_TURN = 18'sd23040;
    localparam logic signed [DIFF_W-1:0] FULL_TURN = 18'sd46080;
    localparam logic [TILT_W-1:0]        TILT_MAX_RESET = 15'd6528;

    // opcodes
    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    // register indexes
    localparam logic REG_TILT_MAX = 1'b0;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // difference a - b, unwrapped by a full turn for strictly opposite signs
    function automatic logic signed [DIFF_W-1:0] unwrap(
        input logic signed [POS_W-1:0] a,
        input logic signed [POS_W-1:0] b
    );
        logic signed [DIFF_W-1:0] d;
        logic                     opposite;
        d = DIFF_W'(a) - DIFF_W'(b);
        opposite = ((a > 0) && (b < 0)) || ((a < 0) && (b > 0));
        if (opposite && (d >= HALF_TURN)) begin
            d = d - FULL_TURN;
        end else if (opposite && (d <= -HALF_TURN)) begin
            d = d + FULL_TURN;
        end
        return d;
    endfunction

    // saturate a 36-bit sum to the signed 32-bit range
    function automatic logic signed [COEF_W-1:0] sat32(input logic signed [35:0] v);
        logic signed [35:0] hi;
        logic signed [35:0] lo;
        hi = 36'sh0_7FFF_FFFF;
        lo = -36'sh0_8000_0000;
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[COEF_W-1:0];
    endfunction

endpackage

// File: design/mabp_in_if.sv
// ----------------------------------------------------------------------------
// mabp_in_if
// input channel: coefficient write or convert transaction
// ----------------------------------------------------------------------------
interface mabp_in_if
    import mabp_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     opcode;
    logic [IDX_W-1:0]         coef_index;
    logic signed [COEF_W-1:0] coef_value;
    logic signed [POS_W-1:0]  pos_first;
    logic signed [POS_W-1:0]  pos_second;
    logic signed [POS_W-1:0]  pos_third;

    modport source (
        output valid, opcode, coef_index, coef_value, pos_first, pos_second, pos_third,
        input  ready
    );
    modport sink (
        input  valid, opcode, coef_index, coef_value, pos_first, pos_second, pos_third,
        output ready
    );
endinterface

// File: design/mabp_out_if.sv
// ----------------------------------------------------------------------------
// mabp_out_if
// result channel: angles and beam polynomials of one convert transaction
// ----------------------------------------------------------------------------
interface mabp_out_if
    import mabp_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  base_angle;
    logic [TILT_W-1:0]        tilt_angle;
    logic signed [POS_W-1:0]  third_offset;
    logic signed [COEF_W-1:0] beam_roll;
    logic signed [COEF_W-1:0] beam_pitch;
    logic signed [COEF_W-1:0] beam_yaw;
    logic                     tilt_clamped;

    modport source (
        output valid, base_angle, tilt_angle, third_offset, beam_roll, beam_pitch,
               beam_yaw, tilt_clamped,
        input  ready
    );
    modport sink (
        input  valid, base_angle, tilt_angle, third_offset, beam_roll, beam_pitch,
               beam_yaw, tilt_clamped,
        output ready
    );
endinterface

// File: design/motor_angles_to_beam_polynomial.sv
// ----------------------------------------------------------------------------
// motor_angles_to_beam_polynomial
// motor angles to tilt, offsets and roll/pitch/yaw beam polynomials
//
//   channel   direction  contents
//   i_in      sink       coefficient write or convert transaction
//   o_res     source     base, tilt, offset, roll, pitch, yaw, clamp flag
//   apb       slave      tilt_max register at byte address 0
//
// a write transaction leaves the block idle; a convert transaction is paced
// by the single coefficient memory read port that feeds one Horner step per
// cycle, axes interleaved
// reset clears the coefficient valid bits, so the table reads as zero
// a result waiting on o_res holds the block in its done state; the next
// input transaction is taken once the result register is loaded
// ----------------------------------------------------------------------------
module motor_angles_to_beam_polynomial
    import mabp_pkg::*;
#(
    parameter int POLY_DEGREE = POLY_DEGREE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    mabp_in_if.sink            i_in,
    mabp_out_if.source         o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int COEF_PER_AXIS = POLY_DEGREE + 1;
    localparam int DEPTH         = 3 * COEF_PER_AXIS;
    localparam int AW            = $clog2(DEPTH);
    localparam int KW            = $clog2(COEF_PER_AXIS);
    localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(DEPTH);
    localparam logic [KW-1:0]    K_TOP     = KW'(POLY_DEGREE);
    localparam logic [AW-1:0]    AXIS_STEP = AW'(COEF_PER_AXIS);
    localparam logic [1:0]       AXIS_LAST = 2'd2;

    // coefficient memory and per-entry valid bits
    logic signed [COEF_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]         r_vld;

    // control state
    t_state     r_state, n_state;
    logic [KW-1:0] r_k;
    logic [1:0]    r_axis;
    logic [AW-1:0] r_base;
    logic          r_p_go;
    logic          r_p_first;
    logic [1:0]    r_p_axis;
    logic          r_out_valid;
    logic [TILT_W-1:0] r_tilt_max;

    // datapath registers
    logic signed [COEF_W-1:0] r_acc [3];
    logic signed [50:0]       r_prod;
    logic signed [COEF_W-1:0] r_rd_data;
    logic                     r_rd_vld;
    logic [TILT_W-1:0]        r_tilt;
    logic                     r_clamped;
    logic signed [POS_W-1:0]  r_base_angle;
    logic signed [POS_W-1:0]  r_offset;
    logic [TILT_W-1:0]        r_out_tilt;
    logic                     r_out_clamped;
    logic signed [POS_W-1:0]  r_out_base;
    logic signed [POS_W-1:0]  r_out_offset;
    logic signed [COEF_W-1:0] r_out_roll;
    logic signed [COEF_W-1:0] r_out_pitch;
    logic signed [COEF_W-1:0] r_out_yaw;

    // combinational signals
    logic                     in_acc;
    logic                     do_write;
    logic                     do_convert;
    logic                     cfg_wr;
    logic                     load_out;
    logic [AW-1:0]            rd_addr;
    logic signed [DIFF_W-1:0] t_raw;
    logic signed [DIFF_W-1:0] d3_raw;
    logic signed [DIFF_W-1:0] tmax_s;
    logic [TILT_W-1:0]        tilt_n;
    logic                     clamp_n;
    logic signed [POS_W-1:0]  offset_n;
    logic signed [U_W:0]      u_s;
    logic signed [50:0]       n_prod;
    logic signed [COEF_W-1:0] coef;
    logic signed [51:0]       biased;
    logic signed [35:0]       step_sum;
    logic signed [COEF_W-1:0] step_acc;

    // handshakes
    assign i_in.ready = (r_state == ST_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign do_write   = in_acc && (i_in.opcode == OP_WRITE) && (i_in.coef_index < DEPTH_IDX);
    assign do_convert = in_acc && (i_in.opcode == OP_CONVERT);
    assign load_out   = (r_state == ST_DONE) && (!r_out_valid || o_res.ready);

    // apb register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TILT_MAX);
    assign prdata = (paddr[2] == REG_TILT_MAX) ? {17'd0, r_tilt_max} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tilt_max <= TILT_MAX_RESET;
        end else if (cfg_wr) begin
            r_tilt_max <= pwdata[TILT_W-1:0];
        end
    end

    // angle differences and tilt clamp of the incoming transaction
    always_comb begin
        t_raw  = -unwrap(i_in.pos_first, i_in.pos_second);
        d3_raw = -unwrap(i_in.pos_third, i_in.pos_second);
        tmax_s = DIFF_W'(r_tilt_max);
        if (t_raw > tmax_s) begin
            tilt_n  = r_tilt_max;
            clamp_n = 1'b1;
        end else if (t_raw < 0) begin
            tilt_n  = '0;
            clamp_n = 1'b1;
        end else begin
            tilt_n  = t_raw[TILT_W-1:0];
            clamp_n = 1'b0;
        end
        if (d3_raw > 18'sd32767) begin
            offset_n = 16'sh7FFF;
        end else if (d3_raw < -18'sd32768) begin
            offset_n = 16'sh8000;
        end else begin
            offset_n = d3_raw[POS_W-1:0];
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (do_convert) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if ((r_axis == AXIS_LAST) && (r_k == '0)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // step sequencer: k from top degree down, axes interleaved within each k
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k       <= '0;
            r_axis    <= '0;
            r_base    <= '0;
            r_p_go    <= 1'b0;
            r_p_first <= 1'b0;
            r_p_axis  <= '0;
        end else begin
            r_p_go    <= (r_state == ST_RUN);
            r_p_first <= (r_k == K_TOP);
            r_p_axis  <= r_axis;
            if (do_convert) begin
                r_k    <= K_TOP;
                r_axis <= '0;
                r_base <= '0;
            end else if (r_state == ST_RUN) begin
                if (r_axis == AXIS_LAST) begin
                    r_axis <= '0;
                    r_base <= '0;
                    r_k    <= r_k - 1'b1;
                end else begin
                    r_axis <= r_axis + 1'b1;
                    r_base <= r_base + AXIS_STEP;
                end
            end
        end
    end

    // coefficient valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (do_write) begin
            r_vld[i_in.coef_index[AW-1:0]] <= 1'b1;
        end
    end

    // coefficient memory, one write and one registered read port
    assign rd_addr = r_base + AW'(r_k);

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            mem[i_in.coef_index[AW-1:0]] <= i_in.coef_value;
        end
        r_rd_data <= mem[rd_addr];
        r_rd_vld  <= r_vld[rd_addr];
    end

    // horner multiply stage
    assign u_s    = {1'b0, r_tilt, 3'b000};
    assign n_prod = r_acc[r_axis] * u_s;

    // horner round, add and saturate stage
    always_comb begin
        coef     = r_rd_vld ? r_rd_data : '0;
        biased   = {r_prod[50], r_prod} + 52'sd32768;
        step_sum = biased[51:16] + 36'(coef);
        step_acc = r_p_first ? coef : sat32(step_sum);
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (do_convert) begin
            r_tilt       <= tilt_n;
            r_clamped    <= clamp_n;
            r_base_angle <= i_in.pos_second;
            r_offset     <= offset_n;
        end
        if (r_p_go) begin
            r_acc[r_p_axis] <= step_acc;
        end
        if (load_out) begin
            r_out_tilt    <= r_tilt;
            r_out_clamped <= r_clamped;
            r_out_base    <= r_base_angle;
            r_out_offset  <= r_offset;
            r_out_roll    <= r_acc[0];
            r_out_pitch   <= r_acc[1];
            r_out_yaw     <= r_acc[2];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.base_angle   = r_out_base;
    assign o_res.tilt_angle   = r_out_tilt;
    assign o_res.third_offset = r_out_offset;
    assign o_res.beam_roll    = r_out_roll;
    assign o_res.beam_pitch   = r_out_pitch;
    assign o_res.beam_yaw     = r_out_yaw;
    assign o_res.tilt_clamped = r_out_clamped;

    // no horner step in flight while new transactions are taken
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !r_p_go)
        else $error("horner step in flight while input is ready");

    // tilt under conversion respects the clamp
    a_tilt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_tilt <= r_tilt_max))
        else $error("tilt above tilt_max");

    // a clamped tilt sits at one of the bounds
    a_clamp_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_RUN) && r_clamped) |-> ((r_tilt == '0) || (r_tilt == r_tilt_max)))
        else $error("clamped tilt not at a bound");

    // axis counter stays on the three axes
    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_axis <= AXIS_LAST)
        else $error("axis counter out of range");

    // the result register is loaded only after the last step has drained
    a_load_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> ($past(r_state) == ST_DRAIN) || ($past(r_state) == ST_DONE))
        else $error("result loaded before the steps drained");

endmodule

// File: tb/motor_angles_to_beam_polynomial_tb.sv
// ----------------------------------------------------------------------------
// motor_angles_to_beam_polynomial_tb
// self-checking bench for the motor angle to beam polynomial converter:
// coefficient writes and convert transactions go in through the input
// channel, every result is predicted from a local copy of the coefficient
// table and tilt limit, and compared field by field as it leaves the block;
// the apb port moves the tilt limit between phases while the block is idle
// ----------------------------------------------------------------------------
module motor_angles_to_beam_polynomial_tb
    import mabp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POLY_DEG      = POLY_DEGREE_DEF;
    localparam int COEF_PER_AXIS = POLY_DEG + 1;
    localparam int TABLE_N       = 3 * COEF_PER_AXIS;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RAND_PHASES   = 6;
    localparam int PHASE_ITEMS   = 230;

    localparam logic [2:0] ADDR_TILT_MAX = {REG_TILT_MAX, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED = 3'h4;

    // one input transaction
    typedef struct {
        logic                     opcode;
        logic [IDX_W-1:0]         coef_index;
        logic signed [COEF_W-1:0] coef_value;
        logic signed [POS_W-1:0]  pos_first;
        logic signed [POS_W-1:0]  pos_second;
        logic signed [POS_W-1:0]  pos_third;
    } t_motor_cmd;

    // one result transaction
    typedef struct {
        logic signed [POS_W-1:0]  base_angle;
        logic [TILT_W-1:0]        tilt_angle;
        logic signed [POS_W-1:0]  third_offset;
        logic signed [COEF_W-1:0] roll;
        logic signed [COEF_W-1:0] pitch;
        logic signed [COEF_W-1:0] yaw;
        logic                     clamped;
    } t_beam_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mabp_in_if  cmd_if ();
    mabp_out_if beam_if ();

    // local copy of the block state
    logic signed [COEF_W-1:0] coef_mirror [TABLE_N];
    logic [TILT_W-1:0]        tilt_limit;
    t_beam_result             beam_expect_q [$];

    int         error_count   = 0;
    int         cycle_count   = 0;
    int         rx_hold_left  = 0;
    logic [15:0] rx_pattern   = '1;
    logic [6:0] rx_phase      = '0;
    int         tx_burst_left = 0;
    bit         tx_gaps_on    = 1'b1;

    motor_angles_to_beam_polynomial #(
        .POLY_DEGREE(POLY_DEG)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_res   (beam_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles", $time, cycle_count);
            $display("motor_angles_to_beam_polynomial_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // a - b, moved by a full turn when the operands have strictly opposite signs
    function automatic int wrapped_diff(int a, int b);
        int d;
        d = a - b;
        if ((a > 0 && b < 0) || (a < 0 && b > 0)) begin
            if (d >= int'(HALF_TURN)) begin
                d = d - int'(FULL_TURN);
            end else if (d <= -int'(HALF_TURN)) begin
                d = d + int'(FULL_TURN);
            end
        end
        return d;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // horner evaluation, product rounded half up back to q16.16, saturated per step
    function automatic logic signed [COEF_W-1:0] horner_eval(int axis, longint u);
        longint acc;
        longint prod;
        int     k;
        acc = coef_mirror[axis * COEF_PER_AXIS + POLY_DEG];
        for (k = POLY_DEG - 1; k >= 0; k--) begin
            prod = acc * u;
            acc  = clip32(((prod + 64'sd32768) >>> 16)
                          + longint'(coef_mirror[axis * COEF_PER_AXIS + k]));
        end
        return acc[COEF_W-1:0];
    endfunction

    function automatic t_beam_result predict_beam(t_motor_cmd c);
        t_beam_result r;
        int           t;
        int           d3;
        int           tilt;
        longint       u;
        r.clamped = 1'b0;
        t = -wrapped_diff(c.pos_first, c.pos_second);
        if (t > int'(tilt_limit)) begin
            tilt      = int'(tilt_limit);
            r.clamped = 1'b1;
        end else if (t < 0) begin
            tilt      = 0;
            r.clamped = 1'b1;
        end else begin
            tilt = t;
        end
        d3 = -wrapped_diff(c.pos_third, c.pos_second);
        if (d3 > 32767) begin
            d3 = 32767;
        end
        if (d3 < -32768) begin
            d3 = -32768;
        end
        u = longint'(tilt) * 8;
        r.base_angle   = c.pos_second;
        r.tilt_angle   = tilt[TILT_W-1:0];
        r.third_offset = d3[POS_W-1:0];
        r.roll         = horner_eval(0, u);
        r.pitch        = horner_eval(1, u);
        r.yaw          = horner_eval(2, u);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // offer one transaction, in bursts with random gaps, and predict on acceptance
    task automatic send_cmd(t_motor_cmd c);
        int gap;
        gap = 0;
        if (tx_burst_left == 0) begin
            if (tx_gaps_on && $urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 30);
            end
            tx_burst_left = $urandom_range(1, 16);
        end
        tx_burst_left--;
        @(negedge i_clk);
        if (gap > 0) begin
            cmd_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_if.opcode     = c.opcode;
        cmd_if.coef_index = c.coef_index;
        cmd_if.coef_value = c.coef_value;
        cmd_if.pos_first  = c.pos_first;
        cmd_if.pos_second = c.pos_second;
        cmd_if.pos_third  = c.pos_third;
        cmd_if.valid      = 1'b1;
        @(posedge i_clk);
        while (cmd_if.ready !== 1'b1) @(posedge i_clk);
        if (c.opcode == OP_WRITE) begin
            if (c.coef_index < TABLE_N) begin
                coef_mirror[c.coef_index] = c.coef_value;
            end
        end else begin
            beam_expect_q.push_back(predict_beam(c));
        end
    endtask

    task automatic send_convert(int p1, int p2, int p3);
        t_motor_cmd c;
        c.opcode     = OP_CONVERT;
        c.coef_index = IDX_W'($urandom);
        c.coef_value = $urandom;
        c.pos_first  = p1[POS_W-1:0];
        c.pos_second = p2[POS_W-1:0];
        c.pos_third  = p3[POS_W-1:0];
        send_cmd(c);
    endtask

    task automatic send_coef(int idx, logic signed [COEF_W-1:0] value);
        t_motor_cmd c;
        c.opcode     = OP_WRITE;
        c.coef_index = idx[IDX_W-1:0];
        c.coef_value = value;
        c.pos_first  = POS_W'($urandom);
        c.pos_second = POS_W'($urandom);
        c.pos_third  = POS_W'($urandom);
        send_cmd(c);
    endtask

    task automatic tx_quiet();
        @(negedge i_clk);
        cmd_if.valid = 1'b0;
    endtask

    // stop offering, let every pending result arrive, then let the pipe settle
    task automatic wait_drained();
        tx_quiet();
        while (beam_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // random field generators
    // ------------------------------------------------------------------------

    function automatic int rand_position();
        case ($urandom_range(0, 9))
            0: return int'($signed(POS_W'($urandom)));
            1: begin
                case ($urandom_range(0, 5))
                    0: return 0;
                    1: return int'(HALF_TURN);
                    2: return -int'(HALF_TURN);
                    3: return 32767;
                    4: return -32768;
                    default: return ($urandom_range(0, 1) != 0) ? 1 : -1;
                endcase
            end
            default: return int'($urandom_range(0, 46080)) - int'(HALF_TURN);
        endcase
    endfunction

    function automatic logic signed [COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 32'sh0000_0000;
                    default: return -32'sd1;
                endcase
            end
            default: return $signed($urandom) >>> $urandom_range(8, 28);
        endcase
    endfunction

    // convert with tilt near the active range of the limit about half of the time
    task automatic send_random_convert();
        int p1;
        int p2;
        int p3;
        p2 = rand_position();
        p3 = rand_position();
        if ($urandom_range(0, 1) == 0) begin
            p1 = p2 - (int'($urandom_range(0, int'(tilt_limit) + 200)) - 100);
            if (p1 > 32767 || p1 < -32768) begin
                p1 = p2;
            end
        end else begin
            p1 = rand_position();
        end
        send_convert(p1, p2, p3);
    endtask

    task automatic send_random_item();
        if ($urandom_range(0, 99) < 15) begin
            if ($urandom_range(0, 4) == 0) begin
                send_coef($urandom_range(TABLE_N, 31), rand_coef());
            end else begin
                send_coef($urandom_range(0, TABLE_N - 1), rand_coef());
            end
        end else begin
            send_random_convert();
        end
    endtask

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        if (addr == ADDR_TILT_MAX) begin
            tilt_limit = data[TILT_W-1:0];
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // read the tilt limit back and compare with the local copy
    task automatic apb_check_limit();
        logic [31:0] got;
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = ADDR_TILT_MAX;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        got = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (got[TILT_W-1:0] !== tilt_limit) begin
            $display("%0t tilt_max readback expected %h actual %h",
                     $time, tilt_limit, got[TILT_W-1:0]);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------------

    // receiver stalls on a rotating pattern, or holds off for a counted stretch
    always @(negedge i_clk) begin : beam_receiver
        if (rx_hold_left > 0) begin
            beam_if.ready = 1'b0;
            rx_hold_left--;
        end else begin
            if (rx_phase == '0) begin
                rx_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                         : (16'($urandom) | 16'h0001);
            end
            beam_if.ready = rx_pattern[0];
            rx_pattern    = {rx_pattern[0], rx_pattern[15:1]};
            rx_phase      = rx_phase + 1'b1;
        end
    end

    task automatic cmp_field(string what, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t %s expected %h actual %h", $time, what, want_v, got_v);
            error_count++;
        end
    endtask

    // compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin : beam_check
        t_beam_result want;
        if (i_rst_n === 1'b1 && beam_if.valid === 1'b1 && beam_if.ready === 1'b1) begin
            if (beam_expect_q.size() == 0) begin
                $display("%0t unexpected result, tilt %h roll %h",
                         $time, beam_if.tilt_angle, beam_if.beam_roll);
                error_count++;
            end else begin
                want = beam_expect_q.pop_front();
                cmp_field("base_angle", 32'(want.base_angle), 32'(beam_if.base_angle));
                cmp_field("tilt_angle", 32'(want.tilt_angle), 32'(beam_if.tilt_angle));
                cmp_field("third_offset", 32'(want.third_offset),
                          32'(beam_if.third_offset));
                cmp_field("beam_roll", want.roll, beam_if.beam_roll);
                cmp_field("beam_pitch", want.pitch, beam_if.beam_pitch);
                cmp_field("beam_yaw", want.yaw, beam_if.beam_yaw);
                cmp_field("tilt_clamped", 32'(want.clamped), 32'(beam_if.tilt_clamped));
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // table reads as zero and tilt limit holds its default after reset
    task automatic test_reset_state();
        apb_check_limit();
        send_convert(0, 0, 0);
        send_convert(-3000, 0, 500);
    endtask

    // unwrap on strictly opposite signs, zero operands, clamping edges, offset saturation
    task automatic test_angle_unwrap();
        send_convert(100, -23000, 23000);
        send_convert(-23040, 23040, -23040);
        send_convert(0, -23040, 0);
        send_convert(-32768, 32767, -32768);
        send_convert(32767, -32768, 0);
        send_convert(0, 0, -32768);
        send_convert(-1000, 0, 1000);
        send_convert(-6528, 0, 0);
        send_convert(-6529, 0, 0);
    endtask

    // coefficient writes at the field extremes, slots past the table ignored
    task automatic test_coef_table();
        send_coef(0, 32'sh0001_0000);
        send_coef(1, 32'sh7FFF_FFFF);
        send_coef(COEF_PER_AXIS + POLY_DEG, 32'sh8000_0000);
        send_coef(2 * COEF_PER_AXIS, -32'sd1);
        send_coef(TABLE_N, 32'sh7FFF_FFFF);
        send_coef(31, 32'sh8000_0000);
        send_convert(0, 0, 0);
        send_convert(-6528, 0, 0);
    endtask

    // tilt limit at its extremes, upper data bits dropped, unmapped address ignored
    task automatic test_tilt_limit();
        wait_drained();
        apb_write(ADDR_TILT_MAX, 32'h0000_0000);
        apb_check_limit();
        send_convert(-100, 0, 0);
        wait_drained();
        apb_write(ADDR_TILT_MAX, 32'hFFFF_FFFF);
        apb_check_limit();
        send_convert(0, 32767, 0);
        wait_drained();
        apb_write(ADDR_TILT_MAX, 32'(HALF_TURN));
        apb_write(ADDR_UNMAPPED, 32'h0000_0010);
        apb_check_limit();
        send_convert(-23040, 0, 0);
        wait_drained();
    endtask

    // phases of table reloads and mixed traffic under several tilt limits
    task automatic test_random_traffic();
        int phase;
        int n;
        int k;
        logic [31:0] limit_word;
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            wait_drained();
            case (phase)
                0: limit_word = 32'(TILT_MAX_RESET);
                1: limit_word = 32'(HALF_TURN);
                2: limit_word = 32'h0000_0000;
                3: limit_word = 32'h0000_7FFF;
                default: limit_word = $urandom;
            endcase
            apb_write(ADDR_TILT_MAX, limit_word);
            tx_gaps_on = (phase != 2);
            for (k = 0; k < TABLE_N; k++) begin
                send_coef(k, rand_coef());
            end
            for (n = 0; n < PHASE_ITEMS; n++) begin
                send_random_item();
            end
        end
        tx_gaps_on = 1'b1;
    endtask

    // long receiver hold-off while converts keep coming, so the input stalls
    task automatic test_output_backpressure();
        int n;
        wait_drained();
        rx_hold_left = 400;
        tx_gaps_on   = 1'b0;
        for (n = 0; n < 12; n++) begin
            send_random_convert();
        end
        tx_gaps_on = 1'b1;
    endtask

    // sender waits for every pending result before resuming
    task automatic test_sender_pause();
        int n;
        for (n = 0; n < 20; n++) begin
            send_random_item();
        end
        tx_quiet();
        while (beam_expect_q.size() != 0) @(posedge i_clk);
        for (n = 0; n < 20; n++) begin
            send_random_item();
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        cmd_if.valid      = 1'b0;
        cmd_if.opcode     = OP_WRITE;
        cmd_if.coef_index = '0;
        cmd_if.coef_value = '0;
        cmd_if.pos_first  = '0;
        cmd_if.pos_second = '0;
        cmd_if.pos_third  = '0;
        beam_if.ready     = 1'b1;
        foreach (coef_mirror[i]) begin
            coef_mirror[i] = '0;
        end
        tilt_limit = TILT_MAX_RESET;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_angle_unwrap();
        test_coef_table();
        test_tilt_limit();
        test_random_traffic();
        test_output_backpressure();
        test_sender_pause();

        wait_drained();
        if (error_count == 0) begin
            $display("motor_angles_to_beam_polynomial_tb OK");
        end else begin
            $display("motor_angles_to_beam_polynomial_tb NOT OK");
        end
        $finish;
    end

endmodule
